// ----- hdl/bhtd_pkg.sv -----
// Shared types, constants and the prefix code tables of the block Huffman token decoder.
// No dependencies; every other file of the decoder imports this package.
package bhtd_pkg;

    localparam int BLOCK_COUNT_BITS_DEF = 20;
    localparam int LIMIT_W              = 20;
    localparam int VALUE_W              = 12;
    localparam int CODE_W               = 11;
    localparam int IN_TDATA_W           = 8;
    localparam int OUT_TDATA_W          = 16;
    localparam int RESULT_DEPTH         = 8;
    localparam int RESULT_IDX_W         = 3;
    localparam int RESULT_CNT_W         = 4;

    localparam logic [3:0] SYM_EOB     = 4'd12;
    localparam logic [3:0] SYM_DEAD    = 4'd13;
    localparam logic [3:0] MAX_CAT     = 4'd11;

    typedef enum logic [1:0] {
        MODE_LUMA   = 2'd0,
        MODE_CHROMA = 2'd1,
        MODE_AC     = 2'd2,
        MODE_ZRUN   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SIGNED = 2'd1,
        KIND_ZRUN   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BITS  = 2'd1,
        ST_DRAIN = 2'd2
    } fsm_t;

    typedef struct packed {
        mode_t              mode;
        logic [CODE_W-1:0]  code_shift;
        logic [3:0]         code_count;
        logic [3:0]         extra_left;
        logic [CODE_W-1:0]  extra_accum;
        kind_t              extra_kind;
    } dec_state_t;

    localparam dec_state_t DEC_STATE_RESET = '{
        mode:        MODE_LUMA,
        code_shift:  '0,
        code_count:  '0,
        extra_left:  '0,
        extra_accum: '0,
        extra_kind:  KIND_NONE
    };

    typedef struct packed {
        logic [1:0]         emit_n;
        logic [VALUE_W-1:0] value;
        logic               err;
        logic               dead;
        logic               eob;
    } step_out_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] sym;
    } match_t;

    // Prefix lookup: mode, prefix length and prefix bits (first bit most significant).
    function automatic match_t code_match(mode_t mode, logic [3:0] len,
                                          logic [CODE_W-1:0] code);
        logic [16:0] key;
        match_t      r;
        key = {mode, len, code};
        r   = '{hit: 1'b1, sym: 4'd0};
        case (key)
            {MODE_LUMA, 4'd3, 11'h006}:   r.sym = 4'd0;
            {MODE_LUMA, 4'd3, 11'h005}:   r.sym = 4'd1;
            {MODE_LUMA, 4'd3, 11'h003}:   r.sym = 4'd2;
            {MODE_LUMA, 4'd3, 11'h002}:   r.sym = 4'd3;
            {MODE_LUMA, 4'd3, 11'h000}:   r.sym = 4'd4;
            {MODE_LUMA, 4'd3, 11'h001}:   r.sym = 4'd5;
            {MODE_LUMA, 4'd3, 11'h004}:   r.sym = 4'd6;
            {MODE_LUMA, 4'd4, 11'h00E}:   r.sym = 4'd7;
            {MODE_LUMA, 4'd5, 11'h01E}:   r.sym = 4'd8;
            {MODE_LUMA, 4'd6, 11'h03E}:   r.sym = 4'd9;
            {MODE_LUMA, 4'd7, 11'h07E}:   r.sym = 4'd10;
            {MODE_LUMA, 4'd7, 11'h07F}:   r.sym = 4'd11;
            {MODE_CHROMA, 4'd2, 11'h001}: r.sym = 4'd0;
            {MODE_CHROMA, 4'd2, 11'h000}: r.sym = 4'd1;
            {MODE_CHROMA, 4'd3, 11'h004}: r.sym = 4'd2;
            {MODE_CHROMA, 4'd3, 11'h005}: r.sym = 4'd3;
            {MODE_CHROMA, 4'd4, 11'h00C}: r.sym = 4'd4;
            {MODE_CHROMA, 4'd4, 11'h00D}: r.sym = 4'd5;
            {MODE_CHROMA, 4'd4, 11'h00E}: r.sym = 4'd6;
            {MODE_CHROMA, 4'd5, 11'h01E}: r.sym = 4'd7;
            {MODE_CHROMA, 4'd6, 11'h03E}: r.sym = 4'd8;
            {MODE_CHROMA, 4'd7, 11'h07E}: r.sym = 4'd9;
            {MODE_CHROMA, 4'd8, 11'h0FE}: r.sym = 4'd10;
            {MODE_CHROMA, 4'd8, 11'h0FF}: r.sym = 4'd11;
            {MODE_AC, 4'd2, 11'h000}:     r.sym = 4'd0;
            {MODE_AC, 4'd2, 11'h001}:     r.sym = 4'd1;
            {MODE_AC, 4'd2, 11'h002}:     r.sym = 4'd2;
            {MODE_AC, 4'd3, 11'h006}:     r.sym = SYM_EOB;
            {MODE_AC, 4'd4, 11'h00E}:     r.sym = 4'd3;
            {MODE_AC, 4'd5, 11'h01E}:     r.sym = 4'd4;
            {MODE_AC, 4'd6, 11'h03E}:     r.sym = 4'd5;
            {MODE_AC, 4'd7, 11'h07E}:     r.sym = 4'd6;
            {MODE_AC, 4'd8, 11'h0FE}:     r.sym = 4'd7;
            {MODE_AC, 4'd9, 11'h1FE}:     r.sym = SYM_DEAD;
            {MODE_AC, 4'd10, 11'h3FE}:    r.sym = 4'd8;
            {MODE_AC, 4'd11, 11'h7FE},
            {MODE_AC, 4'd11, 11'h7FF}:    r.sym = 4'd9;
            {MODE_ZRUN, 4'd1, 11'h000}:   r.sym = 4'd0;
            {MODE_ZRUN, 4'd2, 11'h002}:   r.sym = 4'd1;
            {MODE_ZRUN, 4'd3, 11'h006}:   r.sym = 4'd2;
            {MODE_ZRUN, 4'd4, 11'h00E}:   r.sym = 4'd3;
            {MODE_ZRUN, 4'd5, 11'h01E}:   r.sym = 4'd4;
            {MODE_ZRUN, 4'd5, 11'h01F}:   r.sym = 4'd5;
            default:                      r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/bhtd_step.sv -----
// One-bit decode step of the block Huffman token decoder: prefix match, extra bits,
// value extension. Depends on bhtd_pkg.
module bhtd_step (
    input  bhtd_pkg::dec_state_t cur,
    input  logic                 bit_in,
    input  logic                 to_chroma,
    output bhtd_pkg::dec_state_t nxt,
    output bhtd_pkg::step_out_t  res
);
    import bhtd_pkg::*;

    logic [3:0]         pos;
    logic [CODE_W-1:0]  acc_new;
    logic [3:0]         left_new;
    logic [3:0]         len;
    logic [VALUE_W-1:0] pow;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] top_bit;
    logic [CODE_W-1:0]  shift_new;
    logic [3:0]         count_new;
    match_t             m;
    logic [3:0]         sym;

    always_comb begin
        nxt       = cur;
        res       = '0;
        pos       = cur.code_count - cur.extra_left;
        left_new  = cur.extra_left - 4'd1;
        shift_new = {cur.code_shift[CODE_W-2:0], bit_in};
        count_new = cur.code_count + 4'd1;
        m         = code_match(cur.mode, count_new, shift_new);
        sym       = m.hit ? m.sym : SYM_DEAD;
        if (cur.extra_kind == KIND_ZRUN) begin
            acc_new = cur.extra_accum | (CODE_W'(bit_in) << pos);
        end else begin
            acc_new = {cur.extra_accum[CODE_W-2:0], bit_in};
        end
        len     = (cur.code_count == 4'd0 || cur.code_count > MAX_CAT) ? MAX_CAT
                                                                      : cur.code_count;
        pow     = VALUE_W'(1) << len;
        raw     = {1'b0, acc_new} & (pow - VALUE_W'(1));
        top_bit = raw >> (len - 4'd1);

        if (cur.extra_left != 4'd0) begin
            nxt.extra_accum = acc_new;
            nxt.extra_left  = left_new;
            if (left_new == 4'd0) begin
                res.emit_n = 2'd1;
                if (cur.extra_kind == KIND_ZRUN) begin
                    res.value = pow | raw;
                end else if (top_bit[0]) begin
                    res.value = raw;
                end else begin
                    res.value = raw - (pow - VALUE_W'(1));
                end
                nxt.extra_kind  = KIND_NONE;
                nxt.extra_accum = '0;
                nxt.code_shift  = '0;
                nxt.code_count  = '0;
            end
        end else if (!m.hit && count_new < MAX_CAT) begin
            nxt.code_shift = shift_new;
            nxt.code_count = count_new;
        end else begin
            nxt.code_shift = '0;
            nxt.code_count = '0;
            if (sym == SYM_DEAD) begin
                res.emit_n = 2'd1;
                res.err    = 1'b1;
                res.dead   = 1'b1;
            end else begin
                case (cur.mode)
                    MODE_ZRUN: begin
                        nxt.mode = MODE_AC;
                        if (sym == 4'd0) begin
                            res.emit_n = 2'd1;
                            res.value  = VALUE_W'(1);
                        end else begin
                            nxt.code_count  = sym;
                            nxt.extra_left  = sym;
                            nxt.extra_accum = '0;
                            nxt.extra_kind  = KIND_ZRUN;
                        end
                    end
                    MODE_AC: begin
                        if (sym == 4'd0) begin
                            res.emit_n = 2'd1;
                            nxt.mode   = MODE_ZRUN;
                        end else if (sym == SYM_EOB) begin
                            res.emit_n = 2'd2;
                            res.eob    = 1'b1;
                            nxt.mode   = to_chroma ? MODE_CHROMA : MODE_LUMA;
                        end else begin
                            nxt.code_count  = sym;
                            nxt.extra_left  = sym;
                            nxt.extra_accum = '0;
                            nxt.extra_kind  = KIND_SIGNED;
                        end
                    end
                    default: begin
                        nxt.mode = MODE_AC;
                        if (sym == 4'd0) begin
                            res.emit_n = 2'd1;
                        end else begin
                            nxt.code_count  = sym;
                            nxt.extra_left  = sym;
                            nxt.extra_accum = '0;
                            nxt.extra_kind  = KIND_SIGNED;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ----- hdl/block_huffman_token_decoder_top.sv -----
// Top level of the block Huffman token decoder: handshakes, sequencer, result buffer.
// Depends on bhtd_pkg and bhtd_step.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] byte_in, tuser start_frame
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata[11:0] token_value,
//                                                 tuser decode_error, tlast last
//   cfg       in   cfg_we                         cfg_wdata luma_block_limit
//
// An accepted byte runs through the single bit-step unit one bit a cycle, stopping early
// after a bad AC prefix; then its results drain one per cycle while m_axis_tready is high.
// A byte taken while halted is accepted but not decoded.
// aresetn is synchronous and active low; it clears the decoder state and the register.
// The block takes no byte while it decodes or drains; m_axis stalls hold the drain.
module block_huffman_token_decoder_top #(
    parameter int BLOCK_COUNT_BITS = bhtd_pkg::BLOCK_COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: [7:0] byte_in
    input  logic [bhtd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: [0] start_frame
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: [11:0] token_value (signed), [15:12] zero
    output logic [bhtd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: [0] decode_error
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_we,
    input  logic [bhtd_pkg::LIMIT_W-1:0]       cfg_wdata
);
    import bhtd_pkg::*;

    localparam int CMP_W = (BLOCK_COUNT_BITS > LIMIT_W) ? BLOCK_COUNT_BITS : LIMIT_W;

    fsm_t                         state_reg, state_next;
    dec_state_t                   dec_reg, dec_next;
    logic [BLOCK_COUNT_BITS-1:0]  luma_done_reg, luma_done_next;
    logic                         halted_reg, halted_next;
    logic [LIMIT_W-1:0]           limit_reg;
    logic [IN_TDATA_W-1:0]        byte_reg;
    logic [2:0]                   bit_idx_reg, bit_idx_next;
    logic [RESULT_CNT_W-1:0]      wptr_reg, wptr_next;
    logic [RESULT_IDX_W-1:0]      rptr_reg, rptr_next;
    logic [VALUE_W-1:0]           val_buf_reg [RESULT_DEPTH];
    logic                         err_buf_reg [RESULT_DEPTH];

    dec_state_t                   step_nxt;
    step_out_t                    step_res;
    logic                         to_chroma;
    logic                         in_xfer, out_xfer;
    logic                         bits_done;
    logic [RESULT_CNT_W-1:0]      wptr_sum;
    logic                         we0, we1;
    logic [RESULT_IDX_W-1:0]      widx0, widx1;

    // Switch DC decoding to chroma once the luma count passes the limit.
    assign to_chroma = CMP_W'(luma_done_reg) > CMP_W'(limit_reg);

    bhtd_step u_step (
        .cur       (dec_reg),
        .bit_in    (byte_reg[bit_idx_reg]),
        .to_chroma (to_chroma),
        .nxt       (step_nxt),
        .res       (step_res)
    );

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_xfer  = m_axis_tvalid && m_axis_tready;
    assign bits_done = step_res.dead || (bit_idx_reg == 3'd7);

    // Results past the eighth of one byte are dropped.
    assign wptr_sum = wptr_reg + RESULT_CNT_W'(step_res.emit_n);
    assign widx0    = wptr_reg[RESULT_IDX_W-1:0];
    assign widx1    = widx0 + RESULT_IDX_W'(1);
    assign we0      = (state_reg == ST_BITS) && (step_res.emit_n != 2'd0)
                      && (wptr_reg < RESULT_CNT_W'(RESULT_DEPTH));
    assign we1      = (state_reg == ST_BITS) && (step_res.emit_n == 2'd2)
                      && (wptr_reg < RESULT_CNT_W'(RESULT_DEPTH - 1));

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (s_axis_tuser || !halted_reg)) begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS: begin
                if (bits_done) begin
                    state_next = (wptr_next == '0) ? ST_IDLE : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_xfer && m_axis_tlast) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        dec_next       = dec_reg;
        luma_done_next = luma_done_reg;
        halted_next    = halted_reg;
        bit_idx_next   = bit_idx_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        case (state_reg)
            ST_IDLE: begin
                bit_idx_next = '0;
                wptr_next    = '0;
                rptr_next    = '0;
                // Start of frame clears the decoder before this byte.
                if (in_xfer && s_axis_tuser) begin
                    dec_next       = DEC_STATE_RESET;
                    luma_done_next = '0;
                    halted_next    = 1'b0;
                end
            end
            ST_BITS: begin
                dec_next     = step_nxt;
                bit_idx_next = bit_idx_reg + 3'd1;
                wptr_next    = (wptr_sum > RESULT_CNT_W'(RESULT_DEPTH))
                               ? RESULT_CNT_W'(RESULT_DEPTH) : wptr_sum;
                if (step_res.dead) begin
                    halted_next = 1'b1;
                end
                // Count luma blocks, saturating.
                if (step_res.eob && !to_chroma && !(&luma_done_reg)) begin
                    luma_done_next = luma_done_reg + BLOCK_COUNT_BITS'(1);
                end
            end
            ST_DRAIN: begin
                if (out_xfer) begin
                    rptr_next = rptr_reg + RESULT_IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Port outputs.
    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_DRAIN);
        m_axis_tdata  = OUT_TDATA_W'(val_buf_reg[rptr_reg]);
        m_axis_tuser  = err_buf_reg[rptr_reg];
        m_axis_tlast  = (RESULT_CNT_W'(rptr_reg) + RESULT_CNT_W'(1)) == wptr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dec_reg       <= DEC_STATE_RESET;
            luma_done_reg <= '0;
            halted_reg    <= 1'b0;
            limit_reg     <= '0;
            bit_idx_reg   <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            dec_reg       <= dec_next;
            luma_done_reg <= luma_done_next;
            halted_reg    <= halted_next;
            bit_idx_reg   <= bit_idx_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload: input byte and result buffer.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            byte_reg <= s_axis_tdata;
        end
        if (we0) begin
            val_buf_reg[widx0] <= step_res.value;
            err_buf_reg[widx0] <= step_res.err;
        end
        if (we1) begin
            val_buf_reg[widx1] <= step_res.value;
            err_buf_reg[widx1] <= step_res.err;
        end
    end

    // Fill count never passes the buffer depth.
    a_wptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wptr_reg <= RESULT_CNT_W'(RESULT_DEPTH))
        else $error("result fill count past buffer depth");

    // Drain only reads filled entries.
    a_rptr_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |-> RESULT_CNT_W'(rptr_reg) < wptr_reg)
        else $error("drain read past filled entries");

    // A bad AC prefix halts the decoder and ends the byte.
    a_dead_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BITS && step_res.dead) |=> (halted_reg && state_reg != ST_BITS))
        else $error("bad prefix did not halt decoding");

    // The final result of a byte returns the block to idle.
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xfer && m_axis_tlast) |=> state_reg == ST_IDLE)
        else $error("block not idle after last result");

endmodule

// ----- sim/block_huffman_token_decoder_top_tb.sv -----
// Self-checking testbench for block_huffman_token_decoder_top: coded byte stream in,
// decoded tokens out, checked against a bit-serial decoder model kept in the bench.
// Depends on bhtd_pkg and the decoder RTL; needs no files or arguments.
module block_huffman_token_decoder_top_tb;
    import bhtd_pkg::*;

    localparam int SETTLE_CYCLES = 40;    // byte decode + drain + margin
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer before giving up
    localparam int PHASE_ITEMS   = 55;

    // Bit-serial decoder model plus the queue of tokens it still owes.
    class token_scoreboard;
        typedef struct packed {
            logic [VALUE_W-1:0] value;
            logic               err;
            logic               last;
        } token_t;

        mode_t                           mode;
        logic [CODE_W-1:0]               shift;
        logic [3:0]                      count;
        logic [3:0]                      extra_left;
        logic [CODE_W-1:0]               accum;
        kind_t                           kind;
        logic [BLOCK_COUNT_BITS_DEF-1:0] blocks;
        bit                              halted;
        logic [LIMIT_W-1:0]              limit;
        token_t                          tokens_due[$];
        token_t                          burst[$];
        int                              errors;

        function new();
            clear_decoder();
            limit  = '0;
            errors = 0;
        endfunction

        // Prefix code of a symbol: {length, bits}, length 0 when the table has none.
        // alt picks the second code of AC category 9.
        static function logic [14:0] code_of(mode_t m, int unsigned sym, bit alt);
            logic [14:0] e;
            e = '0;
            case (m)
                MODE_LUMA: case (sym)
                    0: e = {4'd3, 11'h006};  1: e = {4'd3, 11'h005};  2: e = {4'd3, 11'h003};
                    3: e = {4'd3, 11'h002};  4: e = {4'd3, 11'h000};  5: e = {4'd3, 11'h001};
                    6: e = {4'd3, 11'h004};  7: e = {4'd4, 11'h00E};  8: e = {4'd5, 11'h01E};
                    9: e = {4'd6, 11'h03E}; 10: e = {4'd7, 11'h07E}; 11: e = {4'd7, 11'h07F};
                    default: e = '0;
                endcase
                MODE_CHROMA: case (sym)
                    0: e = {4'd2, 11'h001};  1: e = {4'd2, 11'h000};  2: e = {4'd3, 11'h004};
                    3: e = {4'd3, 11'h005};  4: e = {4'd4, 11'h00C};  5: e = {4'd4, 11'h00D};
                    6: e = {4'd4, 11'h00E};  7: e = {4'd5, 11'h01E};  8: e = {4'd6, 11'h03E};
                    9: e = {4'd7, 11'h07E}; 10: e = {4'd8, 11'h0FE}; 11: e = {4'd8, 11'h0FF};
                    default: e = '0;
                endcase
                MODE_AC: begin
                    case (sym)
                        0: e = {4'd2, 11'h000};  1: e = {4'd2, 11'h001};  2: e = {4'd2, 11'h002};
                        3: e = {4'd4, 11'h00E};  4: e = {4'd5, 11'h01E};  5: e = {4'd6, 11'h03E};
                        6: e = {4'd7, 11'h07E};  7: e = {4'd8, 11'h0FE};  8: e = {4'd10, 11'h3FE};
                        9: e = alt ? {4'd11, 11'h7FF} : {4'd11, 11'h7FE};
                        default: e = '0;
                    endcase
                    if (sym == SYM_EOB)  e = {4'd3, 11'h006};
                    if (sym == SYM_DEAD) e = {4'd9, 11'h1FE};
                end
                default: case (sym)
                    0: e = {4'd1, 11'h000};  1: e = {4'd2, 11'h002};  2: e = {4'd3, 11'h006};
                    3: e = {4'd4, 11'h00E};  4: e = {4'd5, 11'h01E};  5: e = {4'd5, 11'h01F};
                    default: e = '0;
                endcase
            endcase
            return e;
        endfunction

        function void clear_decoder();
            mode       = MODE_LUMA;
            shift      = '0;
            count      = '0;
            extra_left = '0;
            accum      = '0;
            kind       = KIND_NONE;
            blocks     = '0;
            halted     = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        // At most eight tokens per byte.
        function void emit(logic [VALUE_W-1:0] value, logic err);
            token_t t;
            t.value = value;
            t.err   = err;
            t.last  = 1'b0;
            if (burst.size() < 8) burst.insert(burst.size(), t);
        endfunction

        function void start_extra(int unsigned len, kind_t k);
            shift      = '0;
            count      = len[3:0];
            extra_left = len[3:0];
            accum      = '0;
            kind       = k;
        endfunction

        // Decode one accepted byte, LSB first, and queue the tokens it yields.
        function void note_byte(logic [7:0] d, bit sf);
            logic        bitv;
            logic [3:0]  pos;
            logic [14:0] ent;
            int          sym, len, v;
            bit          hit;
            token_t      t;
            if (sf) clear_decoder();
            if (halted) return;
            burst.delete();
            for (int b = 0; b < 8; b++) begin
                bitv = d[b];
                if (extra_left != 0) begin
                    if (kind == KIND_ZRUN) begin
                        // zero-run length bits arrive LSB first
                        pos   = count - extra_left;
                        accum = accum | ({{(CODE_W-1){1'b0}}, bitv} << pos);
                    end else begin
                        accum = {accum[CODE_W-2:0], bitv};
                    end
                    extra_left--;
                    if (extra_left == 0) begin
                        len = count;
                        if (len == 0 || len > MAX_CAT) len = MAX_CAT;
                        if (kind == KIND_ZRUN) begin
                            v = (1 << len) | (accum & ((1 << len) - 1));
                        end else begin
                            // low half of a size category is negative
                            v = accum & ((1 << len) - 1);
                            if (!v[len-1]) v = v - ((1 << len) - 1);
                        end
                        emit(v[VALUE_W-1:0], 1'b0);
                        kind  = KIND_NONE;
                        accum = '0;
                        shift = '0;
                        count = '0;
                    end
                    continue;
                end
                shift = {shift[CODE_W-2:0], bitv};
                count = count + 4'd1;
                hit   = 0;
                sym   = 0;
                for (int s = 0; s < 14; s++) begin
                    for (int a = 0; a < 2; a++) begin
                        ent = code_of(mode, s, a);
                        if (!hit && ent[14:11] == count && ent[10:0] == shift) begin
                            hit = 1;
                            sym = s;
                        end
                    end
                end
                if (!hit) begin
                    if (count < MAX_CAT) continue;
                    sym = SYM_DEAD;
                end
                if (sym == SYM_DEAD) begin
                    // bad AC prefix: one error token, drop the rest of the byte
                    emit('0, 1'b1);
                    halted = 1;
                    shift  = '0;
                    count  = '0;
                    break;
                end
                shift = '0;
                count = '0;
                case (mode)
                    MODE_ZRUN: begin
                        mode = MODE_AC;
                        if (sym == 0) emit(VALUE_W'(1), 1'b0);
                        else start_extra(sym, KIND_ZRUN);
                    end
                    MODE_AC: begin
                        if (sym == 0) begin
                            emit('0, 1'b0);
                            mode = MODE_ZRUN;
                        end else if (sym == SYM_EOB) begin
                            emit('0, 1'b0);
                            emit('0, 1'b0);
                            if (blocks > limit) begin
                                mode = MODE_CHROMA;
                            end else begin
                                if (blocks != '1) blocks++;
                                mode = MODE_LUMA;
                            end
                        end else begin
                            start_extra(sym, KIND_SIGNED);
                        end
                    end
                    default: begin
                        mode = MODE_AC;
                        if (sym == 0) emit('0, 1'b0);
                        else start_extra(sym, KIND_SIGNED);
                    end
                endcase
            end
            for (int i = 0; i < burst.size(); i++) begin
                t      = burst[i];
                t.last = (i == burst.size() - 1);
                tokens_due.insert(tokens_due.size(), t);
            end
        endfunction

        function void check_token(logic [OUT_TDATA_W-1:0] tdata, logic tuser, logic tlast);
            token_t due;
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected token: tdata %h tuser %b tlast %b",
                         $time, tdata, tuser, tlast);
                errors++;
                return;
            end
            due = tokens_due.pop_front();
            if (tdata !== {{(OUT_TDATA_W-VALUE_W){1'b0}}, due.value}) begin
                $display("%0t: token_value mismatch: expected %h, actual %h",
                         $time, due.value, tdata);
                errors++;
            end
            if (tuser !== due.err) begin
                $display("%0t: decode_error mismatch: expected %b, actual %b",
                         $time, due.err, tuser);
                errors++;
            end
            if (tlast !== due.last) begin
                $display("%0t: last mismatch: expected %b, actual %b", $time, due.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [LIMIT_W-1:0]     cfg_wdata     = '0;

    token_scoreboard sb = new();

    // stimulus-side state
    bit                 s_idle         = 1;
    bit                 m_idle         = 1;
    bit                 pressure_armed = 0;
    int                 sent           = 0;
    bit                 bitq[$];
    bit                 frame_start    = 0;
    mode_t              g_dc           = MODE_LUMA;
    logic [19:0]        g_blocks       = '0;
    logic [LIMIT_W-1:0] g_limit        = '0;

    block_huffman_token_decoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: check each token transfer, then pick tready for the next cycle.
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 0;
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (pressure_armed && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (m_idle && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one byte, hold it until the transfer, then note it in the model.
    // tvalid stays high afterwards so back-to-back bytes need no extra assignment.
    task automatic send_byte(logic [7:0] d, bit sf);
        if (s_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= sf;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (sf || !sb.halted) sent++;
        sb.note_byte(d, sf);
    endtask

    // Drop tvalid, wait for every owed token, then let a silent byte finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_limit(v);
        g_limit = v;
    endtask

    // Pack whole bytes from the bit queue, first bit into bit 0.
    task automatic drain_bits();
        logic [7:0] d;
        while (bitq.size() >= 8) begin
            for (int i = 0; i < 8; i++) d[i] = bitq.pop_front();
            send_byte(d, frame_start);
            frame_start = 0;
        end
    endtask

    task automatic put_bits(logic [10:0] val, int len, bit msb_first);
        for (int i = 0; i < len; i++)
            bitq.insert(bitq.size(), msb_first ? val[len-1-i] : val[i]);
        drain_bits();
    endtask

    task automatic put_code(logic [14:0] e);
        put_bits(e[10:0], e[14:11], 1);
    endtask

    task automatic open_frame();
        frame_start = 1;
        g_dc        = MODE_LUMA;
        g_blocks    = '0;
    endtask

    // Pad the last partial byte with random bits.
    task automatic close_frame();
        while (bitq.size() % 8 != 0) bitq.insert(bitq.size(), $urandom_range(0, 1));
        drain_bits();
    endtask

    task automatic dc_sym(int cat, logic [10:0] raw);
        put_code(token_scoreboard::code_of(g_dc, cat, 0));
        if (cat > 0) put_bits(raw, cat, 1);
    endtask

    task automatic ac_sym(int cat, logic [10:0] raw, bit alt);
        put_code(token_scoreboard::code_of(MODE_AC, cat, alt));
        put_bits(raw, cat, 1);
    endtask

    // AC zero followed by a zero-run code; its length bits go LSB first.
    task automatic run_sym(int sym, logic [10:0] raw);
        put_code(token_scoreboard::code_of(MODE_AC, 0, 0));
        put_code(token_scoreboard::code_of(MODE_ZRUN, sym, 0));
        if (sym > 0) put_bits(raw, sym, 0);
    endtask

    // End of block; track which DC table the next block uses.
    task automatic end_block();
        put_code(token_scoreboard::code_of(MODE_AC, SYM_EOB, 0));
        if (g_blocks > g_limit) begin
            g_dc = MODE_CHROMA;
        end else begin
            if (g_blocks != '1) g_blocks++;
            g_dc = MODE_LUMA;
        end
    endtask

    // Bad AC prefix, then one or two bytes the halted block must ignore.
    task automatic kill_stream();
        put_code(token_scoreboard::code_of(MODE_AC, SYM_DEAD, 0));
        close_frame();
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic random_frame();
        int  nblk, cat;
        bit  dead;
        open_frame();
        nblk = $urandom_range(1, 5);
        dead = 0;
        for (int k = 0; k < nblk && !dead; k++) begin
            cat = $urandom_range(0, 11);
            dc_sym(cat, 11'($urandom));
            repeat ($urandom_range(0, 8)) begin
                if ($urandom_range(0, 2) == 0)
                    run_sym($urandom_range(0, 5), 11'($urandom));
                else
                    ac_sym($urandom_range(1, 9), 11'($urandom), $urandom_range(0, 1));
            end
            if ($urandom_range(0, 11) == 0) begin
                kill_stream();
                dead = 1;
            end else begin
                end_block();
            end
        end
        if (!dead) close_frame();
    endtask

    // Raw bytes: arbitrary bit patterns, starts scattered inside.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), (i == 0) || ($urandom_range(0, 7) == 0));
    endtask

    initial begin
        logic [LIMIT_W-1:0] lim;
        int                 goal;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_limit('0);

        // Directed: field extremes, both DC tables, every symbol kind, error and halt.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        open_frame();
        dc_sym(11, 11'h7FF);         // largest positive, crosses a byte
        ac_sym(9, 11'h000, 1);       // second category 9 code, most negative
        run_sym(5, 11'h01F);         // longest zero run
        run_sym(0, 11'h000);         // run of one
        ac_sym(1, 11'h000, 0);
        end_block();                 // counts the first luma block
        dc_sym(11, 11'h000);         // most negative luma value
        end_block();                 // count passes the limit: switch to chroma
        dc_sym(11, 11'h7FF);
        ac_sym(8, 11'h080, 0);
        end_block();
        dc_sym(0, 11'h000);          // chroma category zero
        end_block();
        dc_sym(1, 11'h001);
        kill_stream();

        // Random phases, one register setting each.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       lim = '0;
                1:       lim = '1;
                2:       lim = LIMIT_W'(1);
                3:       lim = LIMIT_W'(3);
                4:       lim = LIMIT_W'($urandom_range(0, 8));
                default: lim = LIMIT_W'($urandom);
            endcase
            if (p > 0) write_limit(lim);
            s_idle = (p != 1 && p != 5);
            m_idle = (p != 5);
            // sender keeps offering while the receiver sits on its hands
            if (p == 1) pressure_armed = 1;
            goal = sent + PHASE_ITEMS;
            while (sent < goal) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else random_frame();
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/bhtd_pkg.sv
hdl/bhtd_step.sv
hdl/block_huffman_token_decoder_top.sv
sim/block_huffman_token_decoder_top_tb.sv
